### design/bpfa_pkg.sv
// Package for the bitmap page-frame allocator.
// Opcodes, register map, command and status types shared by the top level, front end and back end.
`default_nettype none
package bpfa_pkg;

  localparam int unsigned MAX_PAGES_DEF  = 4096;
  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned CFG_W          = 13;
  localparam int unsigned CMD_WORD_W     = 15;
  localparam logic [CFG_W-1:0] TOTAL_PAGES_RST = 13'd4096;

  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_FREE   = 3'd1;
  localparam logic [2:0] OP_MARK   = 3'd2;
  localparam logic [2:0] OP_UNMARK = 3'd3;
  localparam logic [2:0] OP_TEST   = 3'd4;

  localparam logic REG_TOTAL_PAGES = 1'b0;

  typedef enum logic [1:0] {
    K_NONE,
    K_ALLOC,
    K_AREA,
    K_TEST
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic                  set;
    logic                  empty;
    logic [CMD_WORD_W-1:0] ws;
    logic [CMD_WORD_W-1:0] we;
    logic [4:0]            lo;
    logic [4:0]            hi;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } stat_t;

endpackage
`default_nettype wire

### design/bitmap_page_frame_allocator.sv
// Top level of the bitmap page-frame allocator: config port, front end,
// command queue and back end. Depends on bpfa_pkg and all bpfa_* modules.
//
// Usage:
//   Items: drive opcode, start_address, end_address, page_index with start;
//   the item is taken at a clock edge where start is high and busy is low.
//   Results: one per item, shown for exactly one cycle with done high
//   (page_address, success, page_used). The receiver cannot stall; results
//   leave in item order.
//   Config: APB write of total_pages at address 0, read back on prdata.
//   Flow: the front end decodes each item and the queue registers it; the
//   back end then picks a command and sweeps one bitmap word per cycle
//   through the registered RAM read port. Alloc covers min(total_pages,
//   MAX_PAGES) pages and ends early when a free page turns up. Empty ranges
//   and unknown opcodes finish in the back end without a sweep.
//   The two-entry queue lets up to two items wait while one is worked on.
//   Reset: the bitmap RAM is cleared one word per cycle; busy stays high
//   meanwhile. total_pages resets to 4096.
`default_nettype none
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] start_address,
  input  wire logic [31:0] end_address,
  input  wire logic [11:0] page_index,
  output logic             done,
  output logic [31:0]      page_address,
  output logic             success,
  output logic             page_used
);

  logic [CFG_W-1:0] total_pages;
  stat_t            stat;
  logic             q_full;
  logic             q_valid;
  logic             push;
  logic             pop;
  cmd_t             f_cmd;
  cmd_t             q_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOTAL_PAGES) ? 32'(total_pages) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages <= TOTAL_PAGES_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOTAL_PAGES)) begin
      total_pages <= pwdata[CFG_W-1:0];
    end
  end

  bpfa_front #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .start_address (start_address),
    .end_address   (end_address),
    .page_index    (page_index),
    .total_pages   (total_pages),
    .stat          (stat),
    .q_full        (q_full),
    .push          (push),
    .cmd           (f_cmd)
  );

  bpfa_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_cmd),
    .full  (q_full),
    .pop   (pop),
    .dout  (q_cmd),
    .valid (q_valid)
  );

  bpfa_back #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .stat         (stat),
    .done         (done),
    .page_address (page_address),
    .success      (success),
    .page_used    (page_used)
  );

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> busy)
    else $error("busy low right after reset");

  a_success_excl: assert property (@(posedge clk) disable iff (rst)
    success |-> done && !page_used)
    else $error("success without done or with page_used");

  a_test_excl: assert property (@(posedge clk) disable iff (rst)
    page_used |-> done && !success && (page_address == '0))
    else $error("test result mixed with alloc fields");

  a_pop_queued: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid && !stat.clearing)
    else $error("pop from empty queue or during clear");

endmodule
`default_nettype wire

### design/bpfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bpfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/bpfa_queue.sv
// Small FIFO carrying decoded commands from the front end to the back end.
// No dependencies.
`default_nettype none
module bpfa_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  valid
);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign dout  = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= din;
    end
  end

endmodule
`default_nettype wire

### design/bpfa_front.sv
// Front end: accepts items, turns every opcode into a clamped page range
// and pushes the command. Depends on bpfa_pkg.
`default_nettype none
module bpfa_front import bpfa_pkg::*; #(
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [2:0]       opcode,
  input  wire logic [31:0]      start_address,
  input  wire logic [31:0]      end_address,
  input  wire logic [11:0]      page_index,
  input  wire logic [CFG_W-1:0] total_pages,
  input  wire stat_t            stat,
  input  wire logic             q_full,
  output logic                  push,
  output cmd_t                  cmd
);

  localparam int unsigned SH = $clog2(PAGE_BYTES);
  localparam logic [32:0] MAX33 = 33'(MAX_PAGES);
  localparam logic [32:0] ROUND = 33'(PAGE_BYTES - 1);

  logic [32:0] f;
  logic [32:0] l;
  logic [32:0] fc;
  logic [32:0] lc;
  logic [32:0] lm1;
  kind_t       kind;
  logic        set;

  assign busy = q_full || stat.clearing;
  assign push = start && !busy;

  always_comb begin
    f    = '0;
    l    = '0;
    kind = K_NONE;
    set  = 1'b0;
    case (opcode)
      OP_ALLOC: begin
        kind = K_ALLOC;
        l    = 33'(total_pages);
      end
      OP_FREE: begin
        kind = K_AREA;
        f    = 33'(start_address >> SH);
        l    = f + 33'd1;
      end
      OP_MARK, OP_UNMARK: begin
        kind = K_AREA;
        set  = (opcode == OP_MARK);
        f    = 33'(start_address >> SH);
        l    = ({1'b0, end_address} + ROUND) >> SH;
      end
      OP_TEST: begin
        kind = K_TEST;
        f    = 33'(page_index);
        l    = f + 33'd1;
      end
      default: begin
        kind = K_NONE;
      end
    endcase
    fc  = (f > MAX33) ? MAX33 : f;
    lc  = (l > MAX33) ? MAX33 : l;
    lm1 = lc - 33'd1;
  end

  always_comb begin
    cmd.kind  = kind;
    cmd.set   = set;
    cmd.empty = (kind == K_NONE) || (fc >= lc);
    cmd.ws    = CMD_WORD_W'(fc >> 5);
    cmd.we    = CMD_WORD_W'(lm1 >> 5);
    cmd.lo    = fc[4:0];
    cmd.hi    = lm1[4:0];
  end

endmodule
`default_nettype wire

### design/bpfa_back.sv
// Back end: clears the bitmap after reset, then sweeps bitmap words for
// each non-empty command; one result per command. Depends on bpfa_pkg, bpfa_ram.
`default_nettype none
module bpfa_back import bpfa_pkg::*; #(
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire cmd_t        q_cmd,
  output logic             pop,
  output stat_t            stat,
  output logic             done,
  output logic [31:0]      page_address,
  output logic             success,
  output logic             page_used
);

  localparam int unsigned MAP_WORDS = (MAX_PAGES + 31) / 32;
  localparam int unsigned WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned SH = $clog2(PAGE_BYTES);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_SWEEP = 3'b100
  } state_t;

  state_t        state, state_next;
  cmd_t          cur, cur_next;
  logic [WW-1:0] clr, clr_next;
  logic [WW:0]   rd_w, rd_w_next;
  logic [WW-1:0] dw;
  logic          dv, dv_next;
  logic          done_next, success_next, page_used_next;
  logic [31:0]   page_address_next;

  logic          ram_we;
  logic [WW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   rdata;

  logic [WW-1:0] ws_w, we_w;
  logic [31:0]   mask, avail;
  logic [4:0]    idx;
  logic          issue;
  logic          finish;
  logic [63:0]   pa64;

  bpfa_ram #(
    .WIDTH (32),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_w[WW-1:0]),
    .rdata (rdata)
  );

  assign stat.clearing = (state == ST_CLEAR);
  assign ws_w  = cur.ws[WW-1:0];
  assign we_w  = cur.we[WW-1:0];
  assign issue = (state == ST_SWEEP) && (rd_w <= {1'b0, we_w});

  always_comb begin
    mask = 32'hFFFF_FFFF;
    if (dw == ws_w) begin
      mask = mask & (32'hFFFF_FFFF << cur.lo);
    end
    if (dw == we_w) begin
      mask = mask & (32'hFFFF_FFFF >> (5'd31 - cur.hi));
    end
    avail = ~rdata & mask;
    idx   = '0;
    for (int i = 31; i >= 0; i--) begin
      if (avail[i]) begin
        idx = 5'(i);
      end
    end
    pa64 = 64'({dw, idx}) << SH;
  end

  always_comb begin
    state_next        = state;
    cur_next          = cur;
    clr_next          = clr;
    rd_w_next         = rd_w;
    dv_next           = 1'b0;
    pop               = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = dw;
    ram_wdata         = rdata;
    finish            = 1'b0;
    done_next         = 1'b0;
    success_next      = 1'b0;
    page_used_next    = 1'b0;
    page_address_next = '0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = '0;
        clr_next  = clr + 1'b1;
        if (clr == WW'(MAP_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          pop      = 1'b1;
          cur_next = q_cmd;
          if (q_cmd.empty) begin
            done_next = 1'b1;
          end else begin
            rd_w_next  = {1'b0, q_cmd.ws[WW-1:0]};
            state_next = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (issue) begin
          rd_w_next = rd_w + 1'b1;
        end
        if (dv) begin
          case (cur.kind)
            K_ALLOC: begin
              if (avail != '0) begin
                ram_we            = 1'b1;
                ram_wdata         = rdata | (32'd1 << idx);
                success_next      = 1'b1;
                page_address_next = pa64[31:0];
                finish            = 1'b1;
              end else if (dw == we_w) begin
                finish = 1'b1;
              end
            end
            K_AREA: begin
              ram_we    = 1'b1;
              ram_wdata = cur.set ? (rdata | mask) : (rdata & ~mask);
              finish    = (dw == we_w);
            end
            K_TEST: begin
              page_used_next = |(rdata & mask);
              finish         = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
        dv_next = issue && !finish;
        if (finish) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
      dv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      dv    <= dv_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur          <= cur_next;
    rd_w         <= rd_w_next;
    dw           <= rd_w[WW-1:0];
    success      <= success_next;
    page_used    <= page_used_next;
    page_address <= page_address_next;
  end

endmodule
`default_nettype wire
